// ===== hdl/sha256_hasher_macros.svh =====
// Assertion macros shared by the SHA-256 hasher RTL.
`ifndef SHA256_HASHER_MACROS_SVH
`define SHA256_HASHER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sha256_pkg.sv =====
// Types, constants and round functions for the SHA-256 hasher.
package sha256_pkg;

   localparam int BLOCK_BYTES  = 64;
   localparam int BLOCK_BITS   = BLOCK_BYTES * 8;
   localparam int POS_BITS     = $clog2(BLOCK_BYTES);
   localparam int ROUNDS       = 64;
   localparam int RND_BITS     = $clog2(ROUNDS);
   localparam int COUNT_BITS   = 61;
   localparam int BITLEN_W     = 64;
   localparam int DIGEST_WORDS = 8;
   localparam int IDX_BITS     = $clog2(DIGEST_WORDS);

   localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(BLOCK_BYTES - 1);
   localparam logic [POS_BITS-1:0] LEN_POS  = POS_BITS'(BLOCK_BYTES - BITLEN_W / 8);
   localparam logic [RND_BITS-1:0] RND_LAST = RND_BITS'(ROUNDS - 1);
   localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(DIGEST_WORDS - 1);
   localparam logic [7:0]          PAD_MARK = 8'h80;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } sha_req_type;

   typedef struct packed {
      logic [31:0]         digest_word;
      logic [IDX_BITS-1:0] word_index;
      logic                last_word;
   } sha_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   localparam word_type INIT_HASH [0:DIGEST_WORDS-1] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [0:ROUNDS-1] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_sig0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sig1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sig0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic word_type small_sig1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

endpackage

// ===== hdl/sha256_hasher.sv =====
// Streaming SHA-256 hasher: byte input, one-round-per-cycle compression, digest output.
//
// A message byte is taken on each input transfer and shifted into a 512-bit block register.
// When the block fills, the single round unit runs 64 rounds, one per cycle, and
// then the add state adds the result into the chaining value; input is stalled
// meanwhile. On the end-of-message transfer the block is padded one byte
// per cycle up to its end (0x80, zeros, 64-bit big-endian bit length), which is
// one block, or two when fewer than nine bytes were free, each followed by the
// same rounds and add. The eight digest words then go out H0 first, one
// per transfer, and input stays stalled until the last of them is taken.
module sha256_hasher
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  sha_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sha_rsp_type rsp_data
);

   state_type                 state_ff, state_in;
   logic [BLOCK_BITS-1:0]     win_ff, win_in;
   logic [POS_BITS-1:0]       fill_ff, fill_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic [BITLEN_W-1:0]       len_ff, len_in;
   logic [RND_BITS-1:0]       rnd_ff, rnd_in;
   logic [IDX_BITS-1:0]       idx_ff, idx_in;
   word_type                  chain_ff [DIGEST_WORDS];
   word_type                  chain_in [DIGEST_WORDS];
   word_type                  wv_ff [DIGEST_WORDS];
   word_type                  wv_in [DIGEST_WORDS];
   logic                      pad_ff, pad_in;
   logic                      mark_ff, mark_in;
   logic                      lenok_ff, lenok_in;
   logic                      done_ff, done_in;

   logic                      req_xfer;
   logic                      rsp_xfer;
   logic                      block_full;
   logic [COUNT_BITS-1:0]     count_next;
   logic [7:0]                pad_byte;
   word_type                  w_cur;
   word_type                  w_new;
   word_type                  t1;
   word_type                  t2;

   // outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      rsp_data.digest_word = chain_ff[idx_ff];
      rsp_data.word_index  = idx_ff;
      rsp_data.last_word   = (idx_ff == IDX_LAST);
   end

   assign req_xfer   = req_valid && !req_stall;
   assign rsp_xfer   = rsp_valid && !rsp_stall;
   assign block_full = (fill_ff == POS_LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_data.has_byte && block_full) begin
                  state_in = ST_ROUND;
               end else if (req_data.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (block_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (rnd_ff == RND_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (done_ff) begin
               state_in = ST_OUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_xfer && rsp_data.last_word) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // round unit and schedule taps; window word 0 sits in the top bits
   assign w_cur = win_ff[BLOCK_BITS-1 -: 32];
   assign w_new = small_sig1(win_ff[BLOCK_BITS-1-14*32 -: 32])
                + win_ff[BLOCK_BITS-1-9*32 -: 32]
                + small_sig0(win_ff[BLOCK_BITS-1-32 -: 32])
                + w_cur;
   assign t1 = wv_ff[7] + big_sig1(wv_ff[4])
             + ((wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]))
             + ROUND_K[rnd_ff] + w_cur;
   assign t2 = big_sig0(wv_ff[0])
             + ((wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]));

   assign count_next = count_ff + COUNT_BITS'(req_data.has_byte);

   always_comb begin
      if (mark_ff) begin
         pad_byte = PAD_MARK;
      end else if (lenok_ff && fill_ff >= LEN_POS) begin
         pad_byte = len_ff[BITLEN_W-1 -: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   // datapath
   always_comb begin
      win_in   = win_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      len_in   = len_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;
      chain_in = chain_ff;
      wv_in    = wv_ff;
      pad_in   = pad_ff;
      mark_in  = mark_ff;
      lenok_in = lenok_ff;
      done_in  = done_ff;
      case (state_ff)
         ST_IDLE: begin
            wv_in  = chain_ff;
            rnd_in = '0;
            if (req_xfer) begin
               if (req_data.has_byte) begin
                  win_in  = {win_ff[BLOCK_BITS-9:0], req_data.data_byte};
                  fill_in = fill_ff + 1'b1;
               end
               count_in = count_next;
               if (req_data.end_of_message) begin
                  len_in   = {count_next, 3'b000};
                  count_in = '0;
                  pad_in   = 1'b1;
                  mark_in  = 1'b1;
                  lenok_in = 1'b0;
                  done_in  = 1'b0;
               end
            end
         end
         ST_PAD: begin
            wv_in   = chain_ff;
            rnd_in  = '0;
            win_in  = {win_ff[BLOCK_BITS-9:0], pad_byte};
            fill_in = fill_ff + 1'b1;
            if (mark_ff) begin
               mark_in = 1'b0;
               if (fill_ff < LEN_POS) begin
                  lenok_in = 1'b1;
               end
            end else if (lenok_ff && fill_ff >= LEN_POS) begin
               len_in = {len_ff[BITLEN_W-9:0], 8'h00};
               if (block_full) begin
                  done_in = 1'b1;
               end
            end
         end
         ST_ROUND: begin
            wv_in[7] = wv_ff[6];
            wv_in[6] = wv_ff[5];
            wv_in[5] = wv_ff[4];
            wv_in[4] = wv_ff[3] + t1;
            wv_in[3] = wv_ff[2];
            wv_in[2] = wv_ff[1];
            wv_in[1] = wv_ff[0];
            wv_in[0] = t1 + t2;
            win_in   = {win_ff[BLOCK_BITS-33:0], w_new};
            rnd_in   = rnd_ff + 1'b1;
         end
         ST_ADD: begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + wv_ff[i];
            end
            // mark went into the previous block: the next one carries the length
            if (pad_ff && !mark_ff) begin
               lenok_in = 1'b1;
            end
            idx_in = '0;
         end
         ST_OUT: begin
            if (rsp_xfer) begin
               idx_in = idx_ff + 1'b1;
               if (rsp_data.last_word) begin
                  chain_in = INIT_HASH;
                  pad_in   = 1'b0;
                  done_in  = 1'b0;
                  lenok_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      len_ff <= len_in;
      wv_ff  <= wv_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         count_ff <= '0;
         rnd_ff   <= '0;
         idx_ff   <= '0;
         chain_ff <= INIT_HASH;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         lenok_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
         chain_ff <= chain_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         lenok_ff <= lenok_in;
         done_ff  <= done_in;
      end
   end

`include "sha256_hasher_macros.svh"

   `SHA_ASSERT_NOW(a_out_after_final, rsp_valid, done_ff && pad_ff && !mark_ff, "digest out before final block")
   `SHA_ASSERT_NEXT(a_round_to_add, state_ff == ST_ROUND && rnd_ff == RND_LAST, state_ff == ST_ADD, "compression did not end after last round")
   `SHA_ASSERT_NEXT(a_last_to_idle, rsp_xfer && rsp_data.last_word, !req_stall && chain_ff[0] == INIT_HASH[0], "no return to idle after last digest transfer")
   `SHA_ASSERT_NOW(a_pad_block_start, state_ff == ST_PAD && done_ff, 1'b0, "padding continued past length block")

endmodule

// ===== tb/sha256_check_pkg.sv =====
// Digest predictor and scoreboard for the SHA-256 hasher testbench.
package sha256_check_pkg;
   import sha256_pkg::*;

   localparam logic [31:0] HASH_START [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   class digest_scoreboard;
      logic [31:0] chain [8];
      logic [7:0]  blk [64];
      logic [60:0] byte_count;
      sha_rsp_type digest_q [$];
      int          errors;

      function new();
         foreach (chain[k]) chain[k] = HASH_START[k];
         foreach (blk[k]) blk[k] = 8'h00;
         byte_count = '0;
         errors = 0;
      endfunction

      function logic [31:0] rotr(input logic [31:0] x, input int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress();
         logic [31:0] w [16];
         logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wr, w15, w2;
         for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
         e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
         for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
               wr = w[r];
            end else begin
               w15 = w[(r - 15) & 15];
               w2  = w[(r - 2) & 15];
               wr  = w[r & 15] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
                     + w[(r - 7) & 15] + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
               w[r & 15] = wr;
            end
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_CONST[r] + wr;
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
         chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
      endfunction

      // Absorb one accepted transfer; on end of message queue the eight digest words.
      function void absorb_item(input sha_req_type item);
         logic [5:0]  pos;
         logic [63:0] bit_len;
         sha_rsp_type word;
         if (item.has_byte) begin
            pos = byte_count[5:0];
            blk[pos] = item.data_byte;
            byte_count = byte_count + 61'd1;
            if (pos == 6'd63)
               compress();
         end
         if (!item.end_of_message)
            return;
         pos = byte_count[5:0];
         blk[pos] = 8'h80;
         for (int k = int'(pos) + 1; k < 64; k++)
            blk[k] = 8'h00;
         if (pos >= 6'd56) begin
            compress();
            foreach (blk[k]) blk[k] = 8'h00;
         end
         bit_len = {byte_count, 3'b000};
         for (int k = 0; k < 8; k++)
            blk[63 - k] = bit_len[8*k +: 8];
         compress();
         for (int k = 0; k < 8; k++) begin
            word.digest_word = chain[k];
            word.word_index  = k[2:0];
            word.last_word   = (k == 7);
            digest_q.push_back(word);
         end
         foreach (chain[k]) chain[k] = HASH_START[k];
         byte_count = '0;
      endfunction

      task report(input string what);
         $display("MISMATCH at %0t: %s", $time, what);
         errors++;
      endtask

      task check_digest(input sha_rsp_type got);
         sha_rsp_type want;
         if (digest_q.size() == 0) begin
            report($sformatf("unexpected digest word %h index %0d", got.digest_word,
                             got.word_index));
            return;
         end
         want = digest_q.pop_front();
         if (got.digest_word !== want.digest_word)
            report($sformatf("word %0d: digest_word %h, expected %h", want.word_index,
                             got.digest_word, want.digest_word));
         if (got.word_index !== want.word_index)
            report($sformatf("word_index %0d, expected %0d", got.word_index,
                             want.word_index));
         if (got.last_word !== want.last_word)
            report($sformatf("word %0d: last_word %b, expected %b", want.word_index,
                             got.last_word, want.last_word));
      endtask

      function int pending();
         return digest_q.size();
      endfunction
   endclass

endpackage

// ===== tb/testbench.sv =====
// Testbench for the streaming SHA-256 hasher: random messages checked against a predictor.
module testbench;
   import sha256_pkg::*;
   import sha256_check_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   sha_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   sha_rsp_type rsp_data;

   logic steady = 1'b0;
   int   holds_asked = 0;
   int   holds_done = 0;
   int   hold_left = 0;
   int   sent = 0;

   digest_scoreboard sb = new();

   sha256_hasher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Digest side: check each transfer, then pick next cycle's stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_digest(rsp_data);
      if (holds_asked != holds_done) begin
         holds_done <= holds_asked;
         hold_left  <= 400;
         rsp_stall  <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 18);
      end
   end

   function automatic sha_req_type make_item(input logic [7:0] data, input logic has,
                                             input logic last);
      sha_req_type item;
      item.data_byte      = data;
      item.has_byte       = has;
      item.end_of_message = last;
      return item;
   endfunction

   task automatic send_item(input sha_req_type item, input bit counted);
      while (!steady && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sb.absorb_item(item);
      if (counted)
         sent++;
   endtask

   task automatic send_message(input int len, input bit end_alone);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 8)
            send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b0), 1'b0);
         send_item(make_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && !end_alone),
                   1'b1);
      end
      if (end_alone || len == 0)
         send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b1), 1'b1);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      int edge_len [4];
      int msg;
      int len;
      edge_len = '{55, 56, 63, 64};
      msg = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty, "abc" ending on its byte, end alone after bytes, one byte, empty
      send_item(make_item(8'hff, 1'b0, 1'b1), 1'b1);
      send_item(make_item(8'h61, 1'b1, 1'b0), 1'b1);
      send_item(make_item(8'h62, 1'b1, 1'b0), 1'b1);
      send_item(make_item(8'h63, 1'b1, 1'b1), 1'b1);
      send_item(make_item(8'hff, 1'b1, 1'b0), 1'b1);
      send_item(make_item(8'h5a, 1'b0, 1'b0), 1'b0);
      send_item(make_item(8'h00, 1'b1, 1'b0), 1'b1);
      send_item(make_item(8'h00, 1'b0, 1'b1), 1'b1);
      send_item(make_item(8'h80, 1'b1, 1'b1), 1'b1);
      send_item(make_item(8'h00, 1'b0, 1'b1), 1'b1);
      req_valid <= 1'b0;
      wait_drained();

      while (sent < 460) begin
         if (msg == 3)
            steady <= 1'b1;
         else if (msg == 8)
            steady <= 1'b0;
         if (msg == 9)
            holds_asked <= holds_asked + 1;
         if (msg == 13) begin
            req_valid <= 1'b0;
            wait_drained();
         end
         if (msg % 3 == 1 && msg / 3 < 4)
            len = edge_len[msg / 3];
         else if ($urandom_range(99) < 75)
            len = $urandom_range(16);
         else
            len = $urandom_range(130, 17);
         send_message(len, 1'($urandom_range(1)));
         msg++;
      end
      req_valid <= 1'b0;
      wait_drained();
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sha256_pkg.sv
hdl/sha256_hasher.sv
tb/sha256_check_pkg.sv
tb/testbench.sv
